// ===== rtl/rwam_pkg.sv =====
// Shared types and constants of the ring window address mapper.
// No dependencies; imported by rwam_core and ring_window_address_mapper.
package rwam_pkg;

   localparam int MAX_WINDOWS = 16;
   localparam int QW = $clog2(MAX_WINDOWS);
   localparam int CW = QW + 1;

   // op codes
   localparam logic OP_MAP   = 1'b0;
   localparam logic OP_UNMAP = 1'b1;

   // status codes
   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_MAPPED   = 3'd1;
   localparam logic [2:0] STATUS_FULL     = 3'd2;
   localparam logic [2:0] STATUS_NOTHING  = 3'd3;
   localparam logic [2:0] STATUS_OUTSIDE  = 3'd4;
   localparam logic [2:0] STATUS_OVERFLOW = 3'd5;

   // IOMMU commands
   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_MAP   = 2'd1;
   localparam logic [1:0] CMD_UNMAP = 2'd2;

   // register indexes
   localparam logic [1:0] REG_VA_BASE      = 2'd0;
   localparam logic [1:0] REG_WINDOW_COUNT = 2'd1;
   localparam logic [1:0] REG_WINDOW_SIZE  = 2'd2;
   localparam logic [1:0] REG_SLOT_SIZE    = 2'd3;

   typedef struct packed {
      logic        op;
      logic [39:0] phys_addr;
      logic [39:0] virt_addr;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [39:0] addr;
      logic [1:0]  iommu_cmd;
      logic [39:0] iommu_va;
      logic [39:0] iommu_pa;
   } rsp_type;

   typedef struct packed {
      logic [39:0] va_base;
      logic [4:0]  window_count;
      logic [31:0] window_size;
      logic [15:0] slot_size;
   } cfg_type;

   // one pending window as held in the FIFO memory
   typedef struct packed {
      logic [39:0] vbase;
      logic [39:0] pbase;
      logic [15:0] refs;
   } entry_type;

   typedef struct packed {
      logic        valid;
      logic [39:0] vbase;
      logic [39:0] pbase;
      logic [15:0] refs;
   } win_type;

endpackage

// ===== rtl/rwam_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module rwam_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/rwam_core.sv =====
// Request sequencer: open and drain windows, FIFO pointers, result register.
// Depends on rwam_pkg and rwam_ram (pending window FIFO store).
module rwam_core (
   input  logic              clock,
   input  logic              reset,
   input  rwam_pkg::cfg_type cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  rwam_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rwam_pkg::rsp_type rsp_data
);
   import rwam_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CALC = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_POP2 = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]  state_ff, state_in;
   win_type     open_ff, open_in;
   win_type     drain_ff, drain_in;
   logic [QW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   req_type     req_ff, req_in;
   logic [36:0] prod_ws_ff, prod_ws_in;
   logic [31:0] prod_slot_ff, prod_slot_in;
   rsp_type     res_ff, res_in;
   rsp_type     out_ff, out_in;
   logic        out_valid_ff, out_valid_in;

   logic        ram_we, ram_re;
   entry_type   ram_wdata, ram_rdata;

   logic        whole;
   logic [39:0] ws40, slot40, next_vb, phys, slot_addr;
   logic [40:0] next_sum, va_end, drain_hi;
   logic [15:0] refs_dec;
   logic        outside;

   rwam_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_WINDOWS)
   ) u_fifo_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (tail_ff),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (head_ff),
      .rdata (ram_rdata)
   );

   function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
      ptr_inc = (p == QW'(MAX_WINDOWS - 1)) ? '0 : p + QW'(1);
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assign whole    = (cfg.window_count == 5'd1);
   assign ws40     = {8'd0, cfg.window_size};
   assign slot40   = {24'd0, cfg.slot_size};
   assign next_sum = {1'b0, open_ff.vbase} + {9'd0, cfg.window_size};
   assign va_end   = {1'b0, cfg.va_base} + {4'd0, prod_ws_ff};
   assign next_vb  = (next_sum >= va_end) ? cfg.va_base : next_sum[39:0];
   assign drain_hi = {1'b0, drain_ff.vbase} + {9'd0, cfg.window_size};
   assign outside  = (req_ff.virt_addr < drain_ff.vbase) ||
                     ({1'b0, req_ff.virt_addr} > drain_hi);
   assign phys     = drain_ff.pbase + (req_ff.virt_addr - drain_ff.vbase);
   assign refs_dec = drain_ff.refs - 16'd1;
   assign slot_addr = open_ff.vbase + ws40 - {8'd0, prod_slot_ff};

   always_comb begin
      state_in     = state_ff;
      open_in      = open_ff;
      drain_in     = drain_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      req_in       = req_ff;
      prod_ws_in   = prod_ws_ff;
      prod_slot_in = prod_slot_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_wdata    = {open_ff.vbase, open_ff.pbase, open_ff.refs};

      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               ram_re   = 1'b1;        // prefetch FIFO head
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            prod_ws_in   = {32'd0, cfg.window_count} * {5'd0, cfg.window_size};
            prod_slot_in = {16'd0, open_ff.refs + 16'd1} * {16'd0, cfg.slot_size};
            state_in     = S_EXEC;
            if (!whole && req_ff.op == OP_UNMAP && !drain_ff.valid) begin
               if (count_ff != '0) begin
                  drain_in = {1'b1, ram_rdata.vbase, ram_rdata.pbase, ram_rdata.refs};
                  head_in  = ptr_inc(head_ff);
                  count_in = count_ff - CW'(1);
               end else begin
                  res_in   = '{status: STATUS_NOTHING, iommu_cmd: CMD_NONE, default: '0};
                  state_in = S_OUT;
               end
            end
         end
         S_EXEC: begin
            state_in = S_OUT;
            res_in   = '{status: STATUS_OK, iommu_cmd: CMD_NONE, default: '0};
            if (whole) begin
               if (req_ff.op == OP_MAP) begin
                  if (drain_ff.valid) begin
                     res_in.status = STATUS_MAPPED;
                  end else begin
                     drain_in = {1'b1, cfg.va_base, req_ff.phys_addr, 16'd1};
                     res_in   = '{status: STATUS_OK, addr: cfg.va_base,
                                  iommu_cmd: CMD_MAP, iommu_va: cfg.va_base,
                                  iommu_pa: req_ff.phys_addr};
                  end
               end else begin
                  if (!drain_ff.valid) begin
                     res_in.status = STATUS_NOTHING;
                  end else begin
                     drain_in.valid = 1'b0;
                     res_in = '{status: STATUS_OK, addr: cfg.va_base,
                                iommu_cmd: CMD_UNMAP, iommu_va: cfg.va_base,
                                iommu_pa: '0};
                  end
               end
            end else if (req_ff.op == OP_MAP) begin
               if (!open_ff.valid) begin
                  open_in = {1'b1, cfg.va_base, req_ff.phys_addr, 16'd1};
                  res_in  = '{status: STATUS_OK, addr: cfg.va_base + ws40 - slot40,
                              iommu_cmd: CMD_MAP, iommu_va: cfg.va_base,
                              iommu_pa: req_ff.phys_addr};
               end else if (open_ff.pbase != req_ff.phys_addr) begin
                  if (count_ff == CW'(MAX_WINDOWS)) begin
                     res_in.status = STATUS_FULL;
                  end else begin
                     // retire open window into FIFO, open the next in the ring
                     ram_we   = 1'b1;
                     tail_in  = ptr_inc(tail_ff);
                     count_in = count_ff + CW'(1);
                     open_in  = {1'b1, next_vb, req_ff.phys_addr, 16'd1};
                     res_in   = '{status: STATUS_OK, addr: next_vb + ws40 - slot40,
                                  iommu_cmd: CMD_MAP, iommu_va: next_vb,
                                  iommu_pa: req_ff.phys_addr};
                  end
               end else begin
                  if (open_ff.refs == 16'hFFFF) begin
                     res_in.status = STATUS_OVERFLOW;
                  end else begin
                     open_in.refs = open_ff.refs + 16'd1;
                     res_in.addr  = slot_addr;
                  end
               end
            end else begin
               // drain window is valid here: CALC filled it or answered already
               if (outside) begin
                  res_in.status = STATUS_OUTSIDE;
               end else if (refs_dec == 16'd0) begin
                  res_in = '{status: STATUS_OK, addr: phys, iommu_cmd: CMD_UNMAP,
                             iommu_va: drain_ff.vbase, iommu_pa: '0};
                  if (count_ff != '0) begin
                     ram_re   = 1'b1;
                     state_in = S_POP2;
                  end else if (open_ff.valid) begin
                     drain_in      = open_ff;
                     open_in.valid = 1'b0;
                  end else begin
                     drain_in.valid = 1'b0;
                  end
               end else begin
                  drain_in.refs = refs_dec;
                  res_in.addr   = phys;
               end
            end
         end
         S_POP2: begin
            drain_in = {1'b1, ram_rdata.vbase, ram_rdata.pbase, ram_rdata.refs};
            head_in  = ptr_inc(head_ff);
            count_in = count_ff - CW'(1);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!out_valid_ff || rsp_ready) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         open_ff      <= '0;
         drain_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         drain_ff     <= drain_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      prod_ws_ff   <= prod_ws_in;
      prod_slot_ff <= prod_slot_in;
      res_ff       <= res_in;
      out_ff       <= out_in;
   end

endmodule

// ===== rtl/ring_window_address_mapper.sv =====
// Ring window address mapper top level: register block and sequencer.
// Depends on rwam_pkg and rwam_core.
//
//  channel   direction  handshake                 payload
//  req_      in         req_valid / req_ready     req_data  (rwam_pkg::req_type)
//  rsp_      out        rsp_valid / rsp_ready     rsp_data  (rwam_pkg::rsp_type)
//  APB       in/out     psel, penable, pwrite     paddr, pwdata, prdata (64 bit)
//
// One request in flight. Map goes through accept, products, update and result.
// Unmap takes the same steps, skips the update when the ring holds nothing
// to release, and adds a FIFO pop before the result when another window waits
// in the FIFO behind the released one, since the FIFO memory read is registered.
// A finished response waits in its own register, so the next request is
// taken while rsp_ready is low; only its result stalls until taken.
// Synchronous active-high reset empties the ring and restores registers.
// Registers at paddr 0x00 va_base, 0x08 window_count, 0x10 window_size,
// 0x18 slot_size; the user writes them only while the block is idle, unenforced.
module ring_window_address_mapper (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rwam_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rwam_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [63:0]       pwdata,
   output logic [63:0]       prdata,
   output logic              pready
);
   import rwam_pkg::*;

   logic [39:0] va_base_ff;
   logic [4:0]  window_count_ff;
   logic [31:0] window_size_ff;
   logic [15:0] slot_size_ff;
   logic        csr_write;
   logic [1:0]  csr_index;
   cfg_type     cfg;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[4:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         va_base_ff      <= '0;
         window_count_ff <= 5'd1;
         window_size_ff  <= 32'd65536;
         slot_size_ff    <= 16'd2048;
      end else if (csr_write) begin
         case (csr_index)
            REG_VA_BASE:      va_base_ff      <= pwdata[39:0];
            REG_WINDOW_COUNT: window_count_ff <= pwdata[4:0];
            REG_WINDOW_SIZE:  window_size_ff  <= pwdata[31:0];
            REG_SLOT_SIZE:    slot_size_ff    <= pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_VA_BASE:      prdata = {24'd0, va_base_ff};
         REG_WINDOW_COUNT: prdata = {59'd0, window_count_ff};
         REG_WINDOW_SIZE:  prdata = {32'd0, window_size_ff};
         REG_SLOT_SIZE:    prdata = {48'd0, slot_size_ff};
         default:          prdata = '0;
      endcase
   end

   assign cfg = '{va_base: va_base_ff, window_count: window_count_ff,
                  window_size: window_size_ff, slot_size: slot_size_ff};

   // sequencer owns open/drain windows, the pending FIFO and the response
   rwam_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/tb_ring_window_address_mapper.sv =====
// Self-checking testbench for ring_window_address_mapper: a directed table, then random
// map/unmap traffic under several register settings, checked against an in-bench model.
// Depends on rwam_pkg and the RTL of ring_window_address_mapper only.
`timescale 1ns / 1ps

module tb_ring_window_address_mapper;
   import rwam_pkg::*;

   localparam logic [39:0] ALL_ONES = 40'hFF_FFFF_FFFF;
   localparam int PHASE_ITEMS = 215;

   typedef enum logic {ROW_REQUEST, ROW_REGISTER} row_kind_type;

   // one line of the directed table; rsp is only used when exact is set
   typedef struct {
      row_kind_type kind;
      logic        op;
      logic [39:0] phys;
      logic [39:0] virt;
      logic [1:0]  reg_idx;
      logic [63:0] value;
      bit          exact;
      rsp_type     rsp;
   } step_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   ring_window_address_mapper uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Shadow copy of the mapper: registers, open window, drain window and pending FIFO
   // ---------------------------------------------------------------------------------------
   logic [39:0] cfg_va_base = 40'd0;
   logic [4:0]  cfg_count = 5'd1;
   logic [31:0] cfg_wsize = 32'd65536;
   logic [15:0] cfg_ssize = 16'd2048;

   win_type     open_win = '0;
   win_type     drain_win = '0;
   entry_type   pending_mem [MAX_WINDOWS];
   int unsigned pending_head = 0;
   int unsigned pending_tail = 0;
   int unsigned pending_count = 0;

   rsp_type     expected_rsps [$];
   int          mismatches = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;

   // oldest pending window becomes the drain window
   function automatic bit take_oldest_window();
      if (pending_count == 0) return 1'b0;
      drain_win.valid = 1'b1;
      drain_win.vbase = pending_mem[pending_head].vbase;
      drain_win.pbase = pending_mem[pending_head].pbase;
      drain_win.refs  = pending_mem[pending_head].refs;
      pending_head = (pending_head + 1) % MAX_WINDOWS;
      pending_count--;
      return 1'b1;
   endfunction

   // Works out the response to one accepted request and moves the shadow state on.
   // All address sums are done at 64 bits, then cut to 40 as the block does.
   function automatic rsp_type predict_mapping(input req_type r);
      rsp_type     res;
      logic [63:0] ring_end;
      logic [63:0] next_base;
      logic [63:0] sum;
      logic [63:0] top;
      logic [39:0] released;
      res = '0;
      // whole-range mode: a single mapping held as the drain window
      if (cfg_count == 5'd1) begin
         if (r.op == OP_MAP) begin
            if (drain_win.valid) begin
               res.status = STATUS_MAPPED;
            end else begin
               drain_win = '{1'b1, cfg_va_base, r.phys_addr, 16'd1};
               res = {STATUS_OK, cfg_va_base, CMD_MAP, cfg_va_base, r.phys_addr};
            end
         end else if (!drain_win.valid) begin
            res.status = STATUS_NOTHING;
         end else begin
            drain_win.valid = 1'b0;
            res = {STATUS_OK, cfg_va_base, CMD_UNMAP, cfg_va_base, 40'd0};
         end
         return res;
      end
      if (r.op == OP_MAP) begin
         if (!open_win.valid) begin
            open_win = '{1'b1, cfg_va_base, r.phys_addr, 16'd1};
            sum = 64'(cfg_va_base) + 64'(cfg_wsize) - 64'(cfg_ssize);
            res = {STATUS_OK, sum[39:0], CMD_MAP, cfg_va_base, r.phys_addr};
         end else if (open_win.pbase != r.phys_addr) begin
            if (pending_count >= MAX_WINDOWS) begin
               res.status = STATUS_FULL;
            end else begin
               ring_end = 64'(cfg_va_base) + 64'(cfg_count) * 64'(cfg_wsize);
               next_base = 64'(open_win.vbase) + 64'(cfg_wsize);
               if (next_base >= ring_end) next_base = 64'(cfg_va_base);
               pending_mem[pending_tail] = '{open_win.vbase, open_win.pbase, open_win.refs};
               pending_tail = (pending_tail + 1) % MAX_WINDOWS;
               pending_count++;
               open_win = '{1'b1, next_base[39:0], r.phys_addr, 16'd1};
               sum = 64'(next_base[39:0]) + 64'(cfg_wsize) - 64'(cfg_ssize);
               res = {STATUS_OK, sum[39:0], CMD_MAP, next_base[39:0], r.phys_addr};
            end
         end else if (open_win.refs == 16'hFFFF) begin
            res.status = STATUS_OVERFLOW;
         end else begin
            open_win.refs = open_win.refs + 16'd1;
            sum = 64'(open_win.vbase) + 64'(cfg_wsize) -
                  64'(open_win.refs) * 64'(cfg_ssize);
            res.status = STATUS_OK;
            res.addr = sum[39:0];
         end
         return res;
      end
      // ring unmap: the open window is only looked at once nothing else is left to drain
      if (!drain_win.valid) begin
         if (!take_oldest_window()) begin
            res.status = STATUS_NOTHING;
            return res;
         end
      end
      top = 64'(drain_win.vbase) + 64'(cfg_wsize);
      if (r.virt_addr < drain_win.vbase || 64'(r.virt_addr) > top) begin
         res.status = STATUS_OUTSIDE;
         return res;
      end
      sum = 64'(drain_win.pbase) + 64'(r.virt_addr - drain_win.vbase);
      res.status = STATUS_OK;
      res.addr = sum[39:0];
      drain_win.refs = drain_win.refs - 16'd1;
      if (drain_win.refs == 16'd0) begin
         released = drain_win.vbase;
         if (!take_oldest_window()) begin
            if (open_win.valid) begin
               drain_win = open_win;
               open_win.valid = 1'b0;
            end else begin
               drain_win.valid = 1'b0;
            end
         end
         res.iommu_cmd = CMD_UNMAP;
         res.iommu_va = released;
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------
   function automatic logic [39:0] rand_addr();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[39:0];
   endfunction

   // Address relative to a window. Loose picks also land just past either end; strict picks
   // stay inside and never wrap past the top of the 40-bit space.
   function automatic logic [39:0] window_addr(input logic [39:0] vbase, input bit strict);
      logic [63:0] offs;
      logic [63:0] sum;
      case ($urandom_range(0, strict ? 5 : 9))
         0:       offs = 64'd0;
         1:       offs = 64'(cfg_wsize);
         6:       offs = 64'(cfg_wsize) + 64'd1;
         7:       offs = '1;
         default: offs = 64'($urandom_range(0, cfg_wsize));
      endcase
      sum = 64'(vbase) + offs;
      if (strict && sum > 64'(ALL_ONES)) sum = 64'(vbase);
      return sum[39:0];
   endfunction

   // Mostly well-formed traffic: maps that reuse the open window, maps that open a new one,
   // unmaps aimed at the window being released; a few requests of pure noise.
   function automatic req_type ring_request();
      req_type     r;
      int unsigned pick;
      r.op = OP_MAP;
      r.phys_addr = rand_addr();
      r.virt_addr = rand_addr();
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         if (open_win.valid) r.phys_addr = open_win.pbase;
      end else if (pick >= 48 && pick < 93) begin
         r.op = OP_UNMAP;
         if (drain_win.valid) r.virt_addr = window_addr(drain_win.vbase, 1'b0);
         else if (pending_count != 0)
            r.virt_addr = window_addr(pending_mem[pending_head].vbase, 1'b0);
      end else if (pick >= 93) begin
         r.op = logic'($urandom_range(0, 1));
      end
      return r;
   endfunction

   // Present one request; the predictor runs at the edge where it is taken.
   task automatic send_request(input req_type r, input bit exact, input rsp_type typed);
      rsp_type predicted;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      predicted = predict_mapping(r);
      expected_rsps.push_back(exact ? typed : predicted);
   endtask

   // Drop valid and let every outstanding response come back (plus the pipeline depth).
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write then read back one register over APB; only called with the block idle.
   task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 3'b000};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== value) begin
         mismatches++;
         $display("%0t ns: register %0d read back expected %h actual %h",
                  $time, idx, value, prdata);
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_VA_BASE:      cfg_va_base = value[39:0];
         REG_WINDOW_COUNT: cfg_count = value[4:0];
         REG_WINDOW_SIZE:  cfg_wsize = value[31:0];
         REG_SLOT_SIZE:    cfg_ssize = value[15:0];
         default: ;
      endcase
   endtask

   // Unmap everything still mapped. In ring mode an open window with nothing ahead of it
   // can only be reached by opening another window behind it first.
   task automatic drain_ring();
      req_type r;
      forever begin
         r.op = OP_UNMAP;
         r.phys_addr = rand_addr();
         r.virt_addr = rand_addr();
         if (cfg_count == 5'd1) begin
            if (!drain_win.valid) break;
         end else if (drain_win.valid) begin
            r.virt_addr = window_addr(drain_win.vbase, 1'b1);
         end else if (pending_count != 0) begin
            r.virt_addr = window_addr(pending_mem[pending_head].vbase, 1'b1);
         end else if (open_win.valid) begin
            r.op = OP_MAP;
            while (r.phys_addr == open_win.pbase) r.phys_addr = rand_addr();
         end else begin
            break;
         end
         send_request(r, 1'b0, '0);
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Response side: random back-pressure, and every taken response checked field by field
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic check_field(input string name, input logic [39:0] want,
                              input logic [39:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            $display("%0t ns: response with none expected, actual %h", $time, rsp_data);
         end else begin
            want = expected_rsps.pop_front();
            check_field("status", 40'(want.status), 40'(rsp_data.status));
            check_field("addr", want.addr, rsp_data.addr);
            check_field("iommu_cmd", 40'(want.iommu_cmd), 40'(rsp_data.iommu_cmd));
            check_field("iommu_va", want.iommu_va, rsp_data.iommu_va);
            check_field("iommu_pa", want.iommu_pa, rsp_data.iommu_pa);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------------------
   step_row_type directed_steps [21];

   initial begin : stimulus
      logic [39:0] va;
      logic [4:0]  cnt;
      logic [31:0] ws;
      logic [15:0] ss;
      req_type     r;

      // Reset settings first (whole-range mode, va_base 0), then a small two-window ring:
      // va_base 0x100000, 4 KiB windows, 256-byte slots.
      directed_steps = '{
         // unmap with nothing mapped
         '{ROW_REQUEST, OP_UNMAP, 40'h0, 40'h0, REG_VA_BASE, 64'h0, 1'b1,
           {STATUS_NOTHING, 40'h0, CMD_NONE, 40'h0, 40'h0}},
         '{ROW_REQUEST, OP_MAP, 40'h0, ALL_ONES, REG_VA_BASE, 64'h0, 1'b1,
           {STATUS_OK, 40'h0, CMD_MAP, 40'h0, 40'h0}},
         // second map while the whole range is held
         '{ROW_REQUEST, OP_MAP, ALL_ONES, 40'h0, REG_VA_BASE, 64'h0, 1'b1,
           {STATUS_MAPPED, 40'h0, CMD_NONE, 40'h0, 40'h0}},
         // whole-range unmap answers with va_base, not a translation
         '{ROW_REQUEST, OP_UNMAP, ALL_ONES, ALL_ONES, REG_VA_BASE, 64'h0, 1'b1,
           {STATUS_OK, 40'h0, CMD_UNMAP, 40'h0, 40'h0}},
         '{ROW_REQUEST, OP_MAP, ALL_ONES, 40'h0, REG_VA_BASE, 64'h0, 1'b1,
           {STATUS_OK, 40'h0, CMD_MAP, 40'h0, ALL_ONES}},
         '{ROW_REGISTER, OP_MAP, 40'h0, 40'h0, REG_VA_BASE, 64'h10_0000, 1'b0, '0},
         '{ROW_REQUEST, OP_UNMAP, 40'h0, 40'h0, REG_VA_BASE, 64'h0, 1'b1,
           {STATUS_OK, 40'h10_0000, CMD_UNMAP, 40'h10_0000, 40'h0}},
         '{ROW_REGISTER, OP_MAP, 40'h0, 40'h0, REG_WINDOW_COUNT, 64'd2, 1'b0, '0},
         '{ROW_REGISTER, OP_MAP, 40'h0, 40'h0, REG_WINDOW_SIZE, 64'h1000, 1'b0, '0},
         '{ROW_REGISTER, OP_MAP, 40'h0, 40'h0, REG_SLOT_SIZE, 64'h100, 1'b0, '0},
         // empty ring: open window not consulted on unmap
         '{ROW_REQUEST, OP_UNMAP, ALL_ONES, 40'h10_0000, REG_VA_BASE, 64'h0, 1'b1,
           {STATUS_NOTHING, 40'h0, CMD_NONE, 40'h0, 40'h0}},
         '{ROW_REQUEST, OP_MAP, 40'h5000, ALL_ONES, REG_VA_BASE, 64'h0, 1'b1,
           {STATUS_OK, 40'h10_0F00, CMD_MAP, 40'h10_0000, 40'h5000}},
         // reuse, new window, then a new window that wraps to va_base
         '{ROW_REQUEST, OP_MAP, 40'h5000, 40'h0, REG_VA_BASE, 64'h0, 1'b0, '0},
         '{ROW_REQUEST, OP_MAP, 40'h9000, 40'h0, REG_VA_BASE, 64'h0, 1'b0, '0},
         '{ROW_REQUEST, OP_MAP, 40'hA000, 40'h0, REG_VA_BASE, 64'h0, 1'b0, '0},
         // just below the drain window taken from the FIFO
         '{ROW_REQUEST, OP_UNMAP, 40'h0, 40'h0F_FFFF, REG_VA_BASE, 64'h0, 1'b1,
           {STATUS_OUTSIDE, 40'h0, CMD_NONE, 40'h0, 40'h0}},
         // top end is inclusive; then release down through FIFO and open window
         '{ROW_REQUEST, OP_UNMAP, 40'h0, 40'h10_1000, REG_VA_BASE, 64'h0, 1'b0, '0},
         '{ROW_REQUEST, OP_UNMAP, 40'h0, 40'h10_0000, REG_VA_BASE, 64'h0, 1'b0, '0},
         '{ROW_REQUEST, OP_UNMAP, 40'h0, 40'h10_1800, REG_VA_BASE, 64'h0, 1'b0, '0},
         '{ROW_REQUEST, OP_UNMAP, 40'h0, 40'h10_0010, REG_VA_BASE, 64'h0, 1'b0, '0},
         '{ROW_REQUEST, OP_UNMAP, 40'h0, 40'h10_0000, REG_VA_BASE, 64'h0, 1'b1,
           {STATUS_NOTHING, 40'h0, CMD_NONE, 40'h0, 40'h0}}
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 36;
      recv_idle_pct = 52;
      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == ROW_REGISTER) begin
            settle();
            write_register(directed_steps[i].reg_idx, directed_steps[i].value);
         end else begin
            r.op = directed_steps[i].op;
            r.phys_addr = directed_steps[i].phys;
            r.virt_addr = directed_steps[i].virt;
            send_request(r, directed_steps[i].exact, directed_steps[i].rsp);
         end
      end

      // Random phases; each one sets all four registers, extremes among them.
      for (int ph = 0; ph < 6; ph++) begin
         settle();
         case (ph)
            0: begin  // whole-range mode
               va = rand_addr(); cnt = 5'd1; ws = 32'd65536; ss = 16'd2048;
            end
            1: begin
               va = rand_addr(); cnt = 5'd16;
               ws = $urandom_range(1, 32'h1_0000);
               ss = 16'($urandom_range(1, 16'h800));
            end
            2: begin  // top of every range but window_count: sums run past 40 bits
               va = ALL_ONES; cnt = 5'd2; ws = 32'hFFFF_FFFF; ss = 16'hFFFF;
            end
            3: begin  // zero windows: the ring end is va_base, so every new window wraps
               va = 40'h0; cnt = 5'd0; ws = 32'd1; ss = 16'd1;
            end
            4: begin
               va = rand_addr(); cnt = 5'($urandom_range(3, 15));
               ws = $urandom_range(1, 32'hFFFF_FFFF);
               ss = 16'($urandom_range(1, 16'hFFFF));
            end
            default: begin  // slots no smaller than the window: slot addresses fall at or below its base
               va = rand_addr(); cnt = 5'd16;
               ws = $urandom_range(1, 32'h400);
               ss = 16'($urandom_range(16'h400, 16'hFFFF));
            end
         endcase
         send_idle_pct = (ph < 2) ? 36 : (ph < 4) ? 52 : 0;
         recv_idle_pct = (ph < 2) ? 52 : (ph < 4) ? 36 : 0;
         write_register(REG_VA_BASE, 64'(va));
         write_register(REG_WINDOW_COUNT, 64'(cnt));
         write_register(REG_WINDOW_SIZE, 64'(ws));
         write_register(REG_SLOT_SIZE, 64'(ss));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold off mid-phase until the block has answered everything
            if (n == PHASE_ITEMS / 2) settle();
            if (cfg_count == 5'd1) begin
               r.op = logic'($urandom_range(0, 1));
               r.phys_addr = rand_addr();
               r.virt_addr = rand_addr();
            end else begin
               r = ring_request();
            end
            send_request(r, 1'b0, '0);
         end
         drain_ring();
      end

      settle();
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #(2_000_000);
      $display("status: fail");
      $finish;
   end

endmodule
